// ----- hw/rtl/decimal_text_to_fixed_point_defines.svh -----
// Assertion macros shared by the RTL of the decimal text converter.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH

`ifndef SYNTHESIS

`define DTFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtfp: implication check failed");

`define DTFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtfp: next-cycle check failed");

`else

`define DTFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define DTFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/dtfp_pkg.sv -----
`default_nettype none

package dtfp_pkg;

    localparam int unsigned ACC_W   = 63;
    localparam int unsigned SCALE_W = 5;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 64;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Largest accumulator that may still take another digit.
    localparam logic [ACC_W-1:0] DIGIT_LIMIT = 63'd922337203685477579;

    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic [SCALE_W-1:0] pad;
        logic               neg;
        logic               err;
    } pad_req_t;

    // Ten to the power k for k up to 18; zero above that, which only meets a zero magnitude.
    function automatic logic [VALUE_W-1:0] pow10(input logic [SCALE_W-1:0] k);
        logic [VALUE_W-1:0] p;
        begin
            case (k)
                5'd0:    p = 64'd1;
                5'd1:    p = 64'd10;
                5'd2:    p = 64'd100;
                5'd3:    p = 64'd1000;
                5'd4:    p = 64'd10000;
                5'd5:    p = 64'd100000;
                5'd6:    p = 64'd1000000;
                5'd7:    p = 64'd10000000;
                5'd8:    p = 64'd100000000;
                5'd9:    p = 64'd1000000000;
                5'd10:   p = 64'd10000000000;
                5'd11:   p = 64'd100000000000;
                5'd12:   p = 64'd1000000000000;
                5'd13:   p = 64'd10000000000000;
                5'd14:   p = 64'd100000000000000;
                5'd15:   p = 64'd1000000000000000;
                5'd16:   p = 64'd10000000000000000;
                5'd17:   p = 64'd100000000000000000;
                5'd18:   p = 64'd1000000000000000000;
                default: p = 64'd0;
            endcase
            return p;
        end
    endfunction

    // Largest magnitude that survives k padding steps of times ten.
    function automatic logic [ACC_W-1:0] pad_limit(input logic [SCALE_W-1:0] k);
        logic [ACC_W-1:0] t;
        begin
            case (k)
                5'd0:    t = '1;
                5'd1:    t = 63'd922337203685477580;
                5'd2:    t = 63'd92233720368547758;
                5'd3:    t = 63'd9223372036854775;
                5'd4:    t = 63'd922337203685477;
                5'd5:    t = 63'd92233720368547;
                5'd6:    t = 63'd9223372036854;
                5'd7:    t = 63'd922337203685;
                5'd8:    t = 63'd92233720368;
                5'd9:    t = 63'd9223372036;
                5'd10:   t = 63'd922337203;
                5'd11:   t = 63'd92233720;
                5'd12:   t = 63'd9223372;
                5'd13:   t = 63'd922337;
                5'd14:   t = 63'd92233;
                5'd15:   t = 63'd9223;
                5'd16:   t = 63'd922;
                5'd17:   t = 63'd92;
                5'd18:   t = 63'd9;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dtfp_parse.sv -----
`default_nettype none
`include "decimal_text_to_fixed_point_defines.svh"

module dtfp_parse (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [15:0]       s_axis_tdata,  // [7:0] char_code, [12:8] frac_digits
    input  wire logic              s_axis_tlast,  // last_char
    output logic                   req_valid,
    input  wire logic              req_ready,
    output dtfp_pkg::pad_req_t     req
);

    logic                                in_valid_reg;
    logic [dtfp_pkg::CHAR_W-1:0]         char_reg;
    logic [dtfp_pkg::SCALE_W-1:0]        scale_reg;
    logic                                last_reg;

    logic [dtfp_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [dtfp_pkg::SCALE_W-1:0]        dap_reg, dap_next;
    logic                                point_reg, point_next;
    logic                                neg_reg, neg_next;
    logic                                first_reg, first_next;
    logic                                err_reg, err_next;

    logic                                req_valid_reg, req_valid_next;
    dtfp_pkg::pad_req_t                  req_reg, req_next;

    logic                                in_accept;
    logic                                s0_move;
    logic                                s1_free;
    logic                                is_digit;
    logic [dtfp_pkg::SCALE_W-1:0]        have;

    assign s1_free       = !req_valid_reg || req_ready;
    assign s0_move       = in_valid_reg && (!last_reg || s1_free);
    assign s_axis_tready = !in_valid_reg || s0_move;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign is_digit = (char_reg >= dtfp_pkg::CHAR_ZERO) && (char_reg <= dtfp_pkg::CHAR_NINE);

    always_comb begin
        acc_next   = acc_reg;
        dap_next   = dap_reg;
        point_next = point_reg;
        neg_next   = neg_reg;
        first_next = first_reg;
        err_next   = err_reg;
        if (s0_move) begin
            first_next = 1'b0;
            if (!err_reg) begin
                if (first_reg && char_reg == dtfp_pkg::CHAR_MINUS) begin
                    neg_next = 1'b1;
                end else if (char_reg == dtfp_pkg::CHAR_POINT) begin
                    if (point_reg) begin
                        err_next = 1'b1;
                    end else begin
                        point_next = 1'b1;
                        dap_next   = '0;
                    end
                end else if (!is_digit || acc_reg > dtfp_pkg::DIGIT_LIMIT) begin
                    err_next = 1'b1;
                end else if (point_reg && dap_reg >= scale_reg) begin
                    if (char_reg != dtfp_pkg::CHAR_ZERO) begin
                        err_next = 1'b1;
                    end
                end else begin
                    acc_next = {acc_reg[dtfp_pkg::ACC_W-4:0], 3'b000}
                             + {acc_reg[dtfp_pkg::ACC_W-2:0], 1'b0}
                             + {{(dtfp_pkg::ACC_W-4){1'b0}}, char_reg[3:0]};
                    if (point_reg) begin
                        dap_next = dap_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign have = point_next ? dap_next : '0;

    always_comb begin
        req_next.acc = acc_next;
        req_next.pad = (scale_reg > have) ? scale_reg - have : '0;
        req_next.neg = neg_next;
        req_next.err = err_next;
        if (s0_move && last_reg) begin
            req_valid_next = 1'b1;
        end else if (req_valid_reg && req_ready) begin
            req_valid_next = 1'b0;
        end else begin
            req_valid_next = req_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            dap_reg       <= '0;
            point_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            first_reg     <= 1'b1;
            err_reg       <= 1'b0;
            req_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                in_valid_reg <= 1'b1;
            end else if (s0_move) begin
                in_valid_reg <= 1'b0;
            end
            if (s0_move && last_reg) begin
                acc_reg   <= '0;
                dap_reg   <= '0;
                point_reg <= 1'b0;
                neg_reg   <= 1'b0;
                first_reg <= 1'b1;
                err_reg   <= 1'b0;
            end else begin
                acc_reg   <= acc_next;
                dap_reg   <= dap_next;
                point_reg <= point_next;
                neg_reg   <= neg_next;
                first_reg <= first_next;
                err_reg   <= err_next;
            end
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            char_reg  <= s_axis_tdata[7:0];
            scale_reg <= s_axis_tdata[12:8];
            last_reg  <= s_axis_tlast;
        end
        if (s0_move && last_reg) begin
            req_reg <= req_next;
        end
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    `DTFP_ASSERT_IMP(a_first_is_clean, aclk, aresetn, first_reg,
        acc_reg == '0 && dap_reg == '0 && !point_reg && !neg_reg && !err_reg)
    `DTFP_ASSERT_IMP(a_fraction_needs_point, aclk, aresetn, dap_reg != '0, point_reg)

endmodule

`default_nettype wire

// ----- hw/rtl/dtfp_scale.sv -----
`default_nettype none
`include "decimal_text_to_fixed_point_defines.svh"

module dtfp_scale (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire dtfp_pkg::pad_req_t    req,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [63:0]                m_axis_tdata,  // [63:0] fixed_value
    output logic [0:0]                 m_axis_tuser   // [0] valid_res
);

    logic                               prod_valid_reg;
    logic [63:0]                        ll_reg;
    logic [31:0]                        lh_reg;
    logic [31:0]                        hl_reg;
    logic                               prod_err_reg;
    logic                               prod_neg_reg;

    logic                               mag_valid_reg;
    logic [63:0]                        mag_reg;
    logic                               mag_err_reg;
    logic                               mag_neg_reg;

    logic                               out_valid_reg;
    logic [63:0]                        out_data_reg;
    logic                               out_ok_reg;

    logic [dtfp_pkg::VALUE_W-1:0]       p;
    logic [31:0]                        a_lo;
    logic [30:0]                        a_hi;
    logic [31:0]                        p_lo;
    logic [31:0]                        p_hi;
    logic [63:0]                        ll_next;
    logic [31:0]                        lh_next;
    logic [31:0]                        hl_next;
    logic                               err_next;
    logic [63:0]                        mag_next;
    logic [31:0]                        cross_sum;

    logic                               out_free;
    logic                               mag_free;
    logic                               prod_free;
    logic                               prod_load;
    logic                               mag_load;
    logic                               out_load;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign mag_free  = !mag_valid_reg || out_free;
    assign prod_free = !prod_valid_reg || mag_free;
    assign req_ready = prod_free;

    assign prod_load = req_valid && prod_free;
    assign mag_load  = prod_valid_reg && mag_free;
    assign out_load  = mag_valid_reg && out_free;

    assign p    = dtfp_pkg::pow10(req.pad);
    assign a_lo = req.acc[31:0];
    assign a_hi = req.acc[62:32];
    assign p_lo = p[31:0];
    assign p_hi = p[63:32];

    // Only the low 64 bits of the product are kept; the high-by-high term falls outside.
    assign ll_next  = {32'd0, a_lo} * {32'd0, p_lo};
    assign lh_next  = 32'(a_lo * p_hi);
    assign hl_next  = 32'({1'b0, a_hi} * p_lo);
    assign err_next = req.err || (req.acc > dtfp_pkg::pad_limit(req.pad));

    assign cross_sum = lh_reg + hl_reg;
    assign mag_next  = ll_reg + {cross_sum, 32'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            mag_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (prod_load) begin
                prod_valid_reg <= 1'b1;
            end else if (mag_load) begin
                prod_valid_reg <= 1'b0;
            end
            if (mag_load) begin
                mag_valid_reg <= 1'b1;
            end else if (out_load) begin
                mag_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_load) begin
            ll_reg       <= ll_next;
            lh_reg       <= lh_next;
            hl_reg       <= hl_next;
            prod_err_reg <= err_next;
            prod_neg_reg <= req.neg;
        end
        if (mag_load) begin
            mag_reg     <= mag_next;
            mag_err_reg <= prod_err_reg;
            mag_neg_reg <= prod_neg_reg;
        end
        if (out_load) begin
            if (mag_err_reg) begin
                out_data_reg <= '0;
            end else if (mag_neg_reg) begin
                out_data_reg <= 64'd0 - mag_reg;
            end else begin
                out_data_reg <= mag_reg;
            end
            out_ok_reg <= !mag_err_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_ok_reg;

    `DTFP_ASSERT_IMP(a_error_beat_is_zero, aclk, aresetn, out_valid_reg && !out_ok_reg,
        out_data_reg == '0)
    `DTFP_ASSERT_NXT(a_held_stage_keeps_beat, aclk, aresetn, mag_valid_reg && !out_free,
        mag_valid_reg)

endmodule

`default_nettype wire

// ----- hw/rtl/decimal_text_to_fixed_point.sv -----
// Channel   Direction  tdata                              tuser
// s_axis    in         [7:0] char_code, [12:8] frac_digits -      (tlast = last_char)
// m_axis    out        [63:0] fixed_value                  [0] valid_res
//
// One character is taken in every cycle while the result side keeps up.
// A result beat leaves, after its final character is accepted, through the input register,
// parse register, three 32x32 partial products, their sum, then the signed output register.
// Reset is synchronous and active low; it clears the number being parsed and all valid flags.
// A stall on m_axis fills the four result stages first; the next final character then waits
// in the input register and holds back every character behind it.
`default_nettype none

module decimal_text_to_fixed_point (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] char_code, [12:8] frac_digits
    input  wire logic        s_axis_tlast,   // last_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] fixed_value
    output logic [0:0]       m_axis_tuser    // [0] valid_res
);

    logic               req_valid;
    logic               req_ready;
    dtfp_pkg::pad_req_t req;

    dtfp_parse u_parse (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req)
    );

    dtfp_scale u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- sim/tb_decimal_text_to_fixed_point.sv -----
`timescale 1ns / 100ps

module tb_decimal_text_to_fixed_point;

    localparam int unsigned    CYCLE_LIMIT  = 400000;
    localparam int unsigned    RANDOM_CHARS = 1900;
    localparam int unsigned    HOLD_CYCLES  = 300;
    localparam logic [63:0]    PAD_CEILING  = 64'd922337203685477580;
    localparam string          NEAR_LIMIT   = "922337203685477580";

    typedef struct packed {
        logic [63:0] value;
        logic        ok;
    } fixed_result_t;

    typedef struct packed {
        logic [7:0] code;
        logic [4:0] scale;
    } text_beat_t;

    typedef struct {
        string  txt;
        int     scale;
        bit     pinned;
        longint value;
        bit     ok;
    } text_case_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    fixed_result_t expected_values[$];
    text_beat_t    number_text[$];
    int unsigned   mismatch_count;
    int unsigned   cycle_count;
    bit            hold_request;

    logic [63:0] num_mag;
    logic [4:0]  num_frac;
    logic        num_point;
    logic        num_neg;
    logic        num_first;
    logic        num_bad;

    text_case_t directed_cases[23] = '{
        '{"-",                    5,  1'b1, 64'sd0,                    1'b1},
        '{"0",                    0,  1'b1, 64'sd0,                    1'b1},
        '{"9223372036854775799",  0,  1'b1, 64'sd9223372036854775799,  1'b1},
        '{"-9223372036854775799", 0,  1'b1, -64'sd9223372036854775799, 1'b1},
        '{"9223372036854775800",  0,  1'b1, 64'sd0,                    1'b0},
        '{"9",                    18, 1'b1, 64'sd9000000000000000000,  1'b1},
        '{"10",                   18, 1'b1, 64'sd0,                    1'b0},
        '{"1",                    19, 1'b1, 64'sd0,                    1'b0},
        '{"0.000",                31, 1'b1, 64'sd0,                    1'b1},
        '{"1.50",                 1,  1'b1, 64'sd15,                   1'b1},
        '{"1.55",                 1,  1'b1, 64'sd0,                    1'b0},
        '{"1.5.0",                2,  1'b1, 64'sd0,                    1'b0},
        '{"1-",                   0,  1'b1, 64'sd0,                    1'b0},
        '{"--1",                  0,  1'b1, 64'sd0,                    1'b0},
        '{"x12",                  3,  1'b1, 64'sd0,                    1'b0},
        '{"\377",                 0,  1'b1, 64'sd0,                    1'b0},
        '{"/",                    0,  1'b1, 64'sd0,                    1'b0},
        '{":",                    0,  1'b1, 64'sd0,                    1'b0},
        '{"12.34",                4,  1'b0, 64'sd0,                    1'b0},
        '{"-.5",                  3,  1'b0, 64'sd0,                    1'b0},
        '{".",                    2,  1'b0, 64'sd0,                    1'b0},
        '{"007",                  2,  1'b0, 64'sd0,                    1'b0},
        '{"-0.25",                6,  1'b0, 64'sd0,                    1'b0}
    };

    decimal_text_to_fixed_point i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic clear_number_state();
        num_mag   = '0;
        num_frac  = '0;
        num_point = 1'b0;
        num_neg   = 1'b0;
        num_first = 1'b1;
        num_bad   = 1'b0;
    endtask

    // Parses one character and, on the final one, scales the magnitude up to the
    // requested number of fraction digits.
    task automatic parse_char(input logic [7:0] code, input logic [4:0] scale,
                              input logic last, output logic produced,
                              output fixed_result_t res);
        logic first;
        int   have;
        produced = 1'b0;
        res      = '0;
        first    = num_first;
        num_first = 1'b0;
        if (!num_bad) begin
            if (first && code == dtfp_pkg::CHAR_MINUS) begin
                num_neg = 1'b1;
            end else if (code == dtfp_pkg::CHAR_POINT) begin
                if (num_point) begin
                    num_bad = 1'b1;
                end else begin
                    num_point = 1'b1;
                    num_frac  = '0;
                end
            end else if (code < dtfp_pkg::CHAR_ZERO || code > dtfp_pkg::CHAR_NINE
                         || num_mag > {1'b0, dtfp_pkg::DIGIT_LIMIT}) begin
                num_bad = 1'b1;
            end else if (num_point && num_frac >= scale) begin
                if (code != dtfp_pkg::CHAR_ZERO) begin
                    num_bad = 1'b1;
                end
            end else begin
                num_mag = num_mag * 64'd10 + 64'(code - dtfp_pkg::CHAR_ZERO);
                if (num_point) begin
                    num_frac = num_frac + 5'd1;
                end
            end
        end
        if (last) begin
            have = num_point ? int'(num_frac) : 0;
            while (!num_bad && have < int'(scale)) begin
                if (num_mag > PAD_CEILING) begin
                    num_bad = 1'b1;
                end else begin
                    num_mag = num_mag * 64'd10;
                end
                have++;
            end
            produced  = 1'b1;
            res.ok    = !num_bad;
            res.value = num_bad ? 64'd0 : (num_neg ? -num_mag : num_mag);
            clear_number_state();
        end
    endtask

    task automatic feed_char(input logic [7:0] code, input logic [4:0] scale, input logic last,
                             input int gap, input bit pinned, input longint pin_value,
                             input bit pin_ok);
        logic          produced;
        fixed_result_t res;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, scale, code};
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        parse_char(code, scale, last, produced, res);
        if (produced) begin
            if (pinned) begin
                res.value = pin_value;
                res.ok    = pin_ok;
            end
            expected_values.insert(expected_values.size(), res);
        end
    endtask

    function automatic logic [7:0] any_digit();
        return dtfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Mostly well-formed numbers with random content; some are broken on purpose
    // and some are plain byte noise with the scale changing from beat to beat.
    task automatic build_number();
        int         kind;
        int         int_len;
        int         frac_len;
        int         prefix_len;
        int         pos;
        logic [4:0] scale;
        text_beat_t b;
        number_text.delete();
        kind  = $urandom_range(0, 99);
        scale = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(19, 31)) : 5'($urandom_range(0, 18));
        if (kind < 12) begin
            repeat ($urandom_range(1, 8)) begin
                b.code  = 8'($urandom_range(0, 255));
                b.scale = 5'($urandom_range(0, 31));
                number_text.insert(number_text.size(), b);
            end
        end else begin
            b.scale = scale;
            if ($urandom_range(0, 2) == 0) begin
                b.code = dtfp_pkg::CHAR_MINUS;
                number_text.insert(number_text.size(), b);
            end
            pos = $urandom_range(0, 9);
            if (pos == 0) begin
                int_len = 0;
            end else if (pos < 3) begin
                int_len = $urandom_range(15, 20);
            end else begin
                int_len = $urandom_range(1, 6);
            end
            prefix_len = (int_len >= 15 && $urandom_range(0, 1) == 1) ? $urandom_range(10, 18) : 0;
            for (int i = 0; i < int_len; i++) begin
                b.code = (i < prefix_len) ? 8'(NEAR_LIMIT[i]) : any_digit();
                number_text.insert(number_text.size(), b);
            end
            if ($urandom_range(0, 9) < 6) begin
                b.code = dtfp_pkg::CHAR_POINT;
                number_text.insert(number_text.size(), b);
                frac_len = $urandom_range(0, (int'(scale) + 3 > 20) ? 20 : int'(scale) + 3);
                for (int i = 0; i < frac_len; i++) begin
                    if (i < int'(scale) || $urandom_range(0, 4) == 0) begin
                        b.code = any_digit();
                    end else begin
                        b.code = dtfp_pkg::CHAR_ZERO;
                    end
                    number_text.insert(number_text.size(), b);
                end
            end
            if (number_text.size() == 0) begin
                b.code = any_digit();
                number_text.insert(number_text.size(), b);
            end
            if (kind < 25) begin
                pos = $urandom_range(0, number_text.size() - 1);
                case ($urandom_range(0, 3))
                    0: number_text[pos].code = 8'($urandom_range(0, 255));
                    1: begin
                        b.code = dtfp_pkg::CHAR_POINT;
                        number_text.insert(pos, b);
                    end
                    2: begin
                        b.code = dtfp_pkg::CHAR_MINUS;
                        number_text.insert(pos, b);
                    end
                    default: number_text[pos].scale = 5'($urandom_range(0, 31));
                endcase
            end
        end
    endtask

    always @(posedge aclk) begin
        fixed_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_values.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result beat: value %0d valid %0b",
                             $signed(m_axis_tdata), m_axis_tuser[0]);
                end
            end else begin
                want = expected_values[0];
                expected_values.delete(0);
                if (m_axis_tdata !== want.value || m_axis_tuser[0] !== want.ok) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Result mismatch: expected %0d valid %0b, got %0d valid %0b",
                                 $signed(want.value), want.ok, $signed(m_axis_tdata),
                                 m_axis_tuser[0]);
                    end
                end
            end
        end
    end

    initial begin
        int stall;
        int calm_left;
        bit calm;
        m_axis_tready <= 1'b0;
        calm_left = 0;
        calm = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(8, 24);
            end
            calm_left--;
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = calm ? 0 : $urandom_range(0, 12);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("** decimal_text_to_fixed_point: FAILED **");
        $finish;
    end

    initial begin
        int          gap;
        int          number_index;
        int unsigned random_chars;
        bit          calm;
        text_case_t  tc;
        mismatch_count = 0;
        hold_request   = 1'b0;
        clear_number_state();
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_cases[i]) begin
            tc = directed_cases[i];
            for (int k = 0; k < tc.txt.len(); k++) begin
                gap = $urandom_range(0, 3);
                feed_char(8'(tc.txt[k]), 5'(tc.scale), k == tc.txt.len() - 1, gap,
                          tc.pinned, tc.value, tc.ok);
            end
        end

        random_chars = 0;
        number_index = 0;
        while (random_chars < RANDOM_CHARS) begin
            if (number_index == 100) begin
                hold_request = 1'b1;
            end
            if (number_index == 170) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (expected_values.size() != 0) @(posedge aclk);
            end
            build_number();
            calm = (number_index >= 100 && number_index < 160) || $urandom_range(0, 3) == 0;
            foreach (number_text[k]) begin
                gap = calm ? 0 : $urandom_range(0, 12);
                feed_char(number_text[k].code, number_text[k].scale,
                          k == number_text.size() - 1, gap, 1'b0, 0, 1'b0);
                random_chars++;
            end
            number_index++;
        end

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (expected_values.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** decimal_text_to_fixed_point: PASSED **");
        end else begin
            $display("** decimal_text_to_fixed_point: FAILED **");
        end
        $finish;
    end

endmodule
